// ===== design/sxfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver package
// Shared constants, register indexes and the command and status bundles that
// pass between the controller and the datapath of the frame receiver.
// ----------------------------------------------------------------------------
package sxfr_pkg;

    // Default largest frame length in bytes.
    localparam int MAX_FRAME_DEF = 32;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int LFI_W      = 5;
    localparam int OVH_W      = 6;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LFI  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OVH  = 2'd2;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] SYNC_RST = 8'd85;
    localparam logic [LFI_W-1:0]  LFI_RST  = 5'd4;
    localparam logic [OVH_W-1:0]  OVH_RST  = 6'd6;

    // Saturation value of the drop counter.
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic prime;
        logic scan;
        logic emit_rd;
        logic emit_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             accept;
        logic             scan_done;
        logic             out_free;
        logic             emit_last;
        logic             post_done;
        logic [CNT_W-1:0] drop_cnt;
    } t_stat;

endpackage

// ===== design/sxfr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sxfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sxfr_dp.sv =====
// ----------------------------------------------------------------------------
// Frame receiver datapath
// Holds the configuration, the byte window in a circular buffer, the scan
// pointers, the running checksum, the drop counter and the output register.
// ----------------------------------------------------------------------------
module sxfr_dp #(
    parameter int MAX_FRAME = sxfr_pkg::MAX_FRAME_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sxfr_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [sxfr_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic [sxfr_pkg::BYTE_W-1:0]       i_rx_byte,
    input  sxfr_pkg::t_cmd                    i_cmd,
    output sxfr_pkg::t_stat                   o_stat,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [sxfr_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int AW    = $clog2(MAX_FRAME + 1);
    localparam int DEPTH = 1 << AW;
    localparam int LW    = sxfr_pkg::LEN_W;
    localparam int BW    = sxfr_pkg::BYTE_W;
    localparam int CW    = sxfr_pkg::CNT_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_FRAME);

    // Configuration registers.
    logic [BW-1:0]                r_sync;
    logic [sxfr_pkg::LFI_W-1:0]   r_lfi;
    logic [sxfr_pkg::OVH_W-1:0]   r_ovh;

    // Window pointers and scan state.
    logic [AW-1:0] r_head, r_pos, r_tail, r_eptr;
    logic [BW-1:0] r_xor, r_len_byte;
    logic [sxfr_pkg::CNT_W-1:0] r_drop;

    // Output register.
    logic                       r_out_valid;
    logic [BW-1:0]              r_out_byte;
    logic                       r_out_last;
    logic [sxfr_pkg::CNT_W-1:0] r_out_cnt;

    // Combinational scan terms.
    logic [BW-1:0] w_rdata;
    logic [AW-1:0] w_raddr, w_fill_m1, w_fill, w_scan_pos;
    logic [LW-1:0] w_fill_l, w_frame_len;
    logic [BW-1:0] w_len_src;
    logic          w_hunt, w_len_here, w_examine, w_chk_ok, w_over, w_complete;
    logic          w_acc, w_rej, w_out_xfer;

    // Window store.
    sxfr_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_in),
        .i_waddr (r_tail),
        .i_wdata (i_rx_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Verdict on the byte at the scan position.
    always_comb begin
        w_fill_m1   = r_pos - r_head;
        w_fill      = w_fill_m1 + AW'(1);
        w_fill_l    = LW'(w_fill);
        w_hunt      = (w_fill == AW'(1)) && (w_rdata != r_sync);
        w_len_here  = (LW'(w_fill_m1) == LW'(r_lfi));
        w_len_src   = w_len_here ? w_rdata : r_len_byte;
        w_examine   = (w_fill_l >= LW'(r_ovh)) && (w_fill_l > LW'(r_lfi));
        w_frame_len = LW'(w_len_src) + LW'(r_ovh);
        w_over      = w_frame_len > MAX_LEN;
        w_complete  = w_fill_l >= w_frame_len;
        w_chk_ok    = (~r_xor) == w_rdata;
        w_acc       = !w_hunt && w_examine && !w_over && w_complete && w_chk_ok;
        w_rej       = !w_hunt &&
                      ((w_examine && (w_over || (w_complete && !w_chk_ok))) ||
                       (!(w_examine && (w_over || w_complete)) &&
                        (w_fill_l >= MAX_LEN)));
        if (w_rej) begin
            w_scan_pos = r_head + AW'(1);
        end else begin
            w_scan_pos = r_pos + AW'(1);
        end
    end

    // Read address selection; priming reads the first byte of the window.
    always_comb begin
        if (i_cmd.scan) begin
            w_raddr = w_scan_pos;
        end else if (i_cmd.emit_rd) begin
            w_raddr = r_eptr;
        end else if (i_cmd.prime) begin
            w_raddr = r_head;
        end else begin
            w_raddr = r_pos;
        end
    end

    assign w_out_xfer = r_out_valid && i_m_tready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= sxfr_pkg::SYNC_RST;
            r_lfi  <= sxfr_pkg::LFI_RST;
            r_ovh  <= sxfr_pkg::OVH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sxfr_pkg::CFG_SYNC: r_sync <= i_cfg_data;
                sxfr_pkg::CFG_LFI:  r_lfi  <= i_cfg_data[sxfr_pkg::LFI_W-1:0];
                sxfr_pkg::CFG_OVH:  r_ovh  <= i_cfg_data[sxfr_pkg::OVH_W-1:0];
                default: ;
            endcase
        end
    end

    // Window pointers and drop counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_pos  <= '0;
            r_tail <= '0;
            r_eptr <= '0;
            r_drop <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_tail <= r_tail + AW'(1);
                r_pos  <= r_head;
            end else if (i_cmd.scan) begin
                if (w_hunt) begin
                    r_pos  <= r_pos + AW'(1);
                    r_head <= r_pos + AW'(1);
                end else if (w_rej) begin
                    r_head <= r_head + AW'(1);
                    r_pos  <= r_head + AW'(1);
                end else if (w_acc) begin
                    r_eptr <= r_head;
                end else begin
                    r_pos <= r_pos + AW'(1);
                end
                if ((w_hunt || w_rej) && (r_drop != sxfr_pkg::CNT_MAX)) begin
                    r_drop <= r_drop + CW'(1);
                end
            end else if (i_cmd.emit_ld) begin
                r_eptr <= r_eptr + AW'(1);
                if (r_eptr == r_pos) begin
                    r_head <= r_pos + AW'(1);
                    r_pos  <= r_pos + AW'(1);
                end
            end
        end
    end

    // Running checksum and captured length byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_xor <= '0;
        end else if (i_cmd.scan) begin
            if (w_hunt || w_rej) begin
                r_xor <= '0;
            end else if (!w_acc) begin
                r_xor <= r_xor ^ w_rdata;
                if (w_len_here) begin
                    r_len_byte <= w_rdata;
                end
            end
        end else if (i_cmd.emit_ld && (r_eptr == r_pos)) begin
            r_xor <= '0;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_out_byte <= w_rdata;
            r_out_last <= (r_eptr == r_pos);
            r_out_cnt  <= r_drop;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.accept    = w_acc;
        o_stat.scan_done = !w_acc && (w_scan_pos == r_tail);
        o_stat.out_free  = !r_out_valid || i_m_tready;
        o_stat.emit_last = (r_eptr == r_pos);
        o_stat.post_done = ((r_pos + AW'(1)) == r_tail);
        o_stat.drop_cnt  = r_drop;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_cnt, r_out_byte};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== design/sxfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame receiver controller
// Sequences loading of a received byte, the window scan and the emission of
// an accepted frame.
// ----------------------------------------------------------------------------
module sxfr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  sxfr_pkg::t_stat i_stat,
    output sxfr_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_PRIME   = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT_LD = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_s_tready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.accept) begin
                    n_state = ST_EMIT_RD;
                end else if (i_stat.scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.emit_rd = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                o_cmd.emit_ld = 1'b1;
                if (!i_stat.emit_last) begin
                    n_state = ST_EMIT_RD;
                end else if (i_stat.post_done) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PRIME;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sync_length_xor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Sync and length framed receiver with inverted-XOR checksum
// Hunts for the sync byte, reads the length byte, checks the checksum and
// streams out good frames with a last mark and the running drop count.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer, only while the block is idle. Each
// byte is written into a circular window buffer and the whole buffered window
// is then scanned again from its first byte after a prime step, one byte at a
// time through the single read port of the window memory. A rejection
// restarts the scan one byte later, so each rejection rescans the rest of the
// window. An accepted frame is read back and emitted byte by byte, each
// through a read state and a load state, and emission waits while the
// output side stalls. Frames up to MAX_FRAME bytes are handled; the
// dropped count saturates at 65535.
module sync_length_xor_frame_receiver #(
    parameter int MAX_FRAME = sxfr_pkg::MAX_FRAME_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [sxfr_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [sxfr_pkg::BYTE_W-1:0]       i_cfg_data,
    // Received byte stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [sxfr_pkg::BYTE_W-1:0]       i_s_tdata,  // [7:0] rx_byte
    // Frame byte stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sxfr_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // [7:0] frame_byte,
                                                          // [23:8] dropped_count
    output logic                              o_m_tlast   // frame_last
);

    sxfr_pkg::t_cmd  w_cmd;
    sxfr_pkg::t_stat w_stat;

    // Controller.
    sxfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    sxfr_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_rx_byte  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef SYNTHESIS
    // A byte transfer is followed by priming and a scan: no byte is taken next.
    a_one_byte_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("byte accepted while the previous one is still scanned");

    // The output register is only loaded when it is empty.
    a_load_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_ld |-> !o_m_tvalid)
        else $error("output register overwritten before transfer");

    // The drop counter never goes backwards.
    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (w_stat.drop_cnt >= $past(w_stat.drop_cnt)))
        else $error("drop counter decreased");

    // Bytes are only taken when no scan or frame emission is under way.
    a_no_take_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_rd || w_cmd.emit_ld || w_cmd.scan) |-> !o_s_tready)
        else $error("input ready during scan or emission");
`endif

endmodule

// ===== dv/sync_length_xor_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Streams received bytes into the frame receiver and checks every emitted
// frame byte, its last mark and the drop count against a cycle-free model of
// the sync hunt, length check, checksum and rescan behaviour. Runs directed
// cases and random traffic under several register settings. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver_tb;

    import sxfr_pkg::*;

    localparam int FRAME_MAX     = MAX_FRAME_DEF;
    // Worst scan of a full window with rescans, plus some margin.
    localparam int SETTLE_CYCLES = 2000;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic [CNT_W-1:0]  dropped;
    } frame_beat_t;

    typedef enum {VERDICT_OPEN, VERDICT_GOOD, VERDICT_BAD} frame_verdict_e;
    typedef enum {DMG_NONE, DMG_CHECKSUM, DMG_BITFLIP} frame_damage_e;

    // Block inputs, all known from time zero.
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = CFG_SYNC;
    logic [BYTE_W-1:0]     i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic [BYTE_W-1:0]     i_s_tdata  = '0;
    logic                  i_m_tready = 1'b0;

    // Block outputs.
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;

    // Model state and register copies.
    logic [BYTE_W-1:0] win_bytes [0:FRAME_MAX];
    int                win_fill   = 0;
    logic [CNT_W-1:0]  drop_total = '0;
    logic [BYTE_W-1:0] cfg_sync   = SYNC_RST;
    logic [LFI_W-1:0]  cfg_lfi    = LFI_RST;
    logic [OVH_W-1:0]  cfg_ovh    = OVH_RST;

    frame_beat_t expected_beats [$];
    int          mismatch_count = 0;
    int          rx_sent        = 0;
    int          out_hold       = 0;
    bit          gaps_on        = 1'b1;

    sync_length_xor_frame_receiver uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] rx_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] frame_byte, [23:8] dropped_count
        .o_m_tlast  (o_m_tlast)    // frame_last
    );

    // Clock generation.
    always #4 i_clk = ~i_clk;

    // Safety net against a hung block.
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the receiver
    // ------------------------------------------------------------------------

    // The drop counter sticks at its maximum.
    function automatic void count_drop();
        if (drop_total != CNT_MAX)
            drop_total = drop_total + CNT_W'(1);
    endfunction

    // Append one received byte to the window and rescan it from the start,
    // queueing the bytes of every frame that the scan accepts.
    task automatic predict_rx_byte(input logic [BYTE_W-1:0] rx);
        logic [BYTE_W-1:0] scan_q [0:FRAME_MAX];
        logic [BYTE_W-1:0] parity;
        int                n, head, pos, fill, flen, i;
        frame_verdict_e    verdict;
        frame_beat_t       beat;
        n = (win_fill > FRAME_MAX) ? FRAME_MAX : win_fill;
        for (i = 0; i < n; i++)
            scan_q[i] = win_bytes[i];
        scan_q[n] = rx;
        n++;
        head = 0;
        pos  = 0;
        while (pos < n) begin
            fill = pos - head + 1;
            // An empty window only opens on the sync byte.
            if (fill == 1 && scan_q[pos] != cfg_sync) begin
                count_drop();
                pos++;
                head = pos;
                continue;
            end
            verdict = VERDICT_OPEN;
            if (fill >= int'(cfg_ovh) && fill > int'(cfg_lfi)) begin
                flen = int'(scan_q[head + int'(cfg_lfi)]) + int'(cfg_ovh);
                if (flen > FRAME_MAX) begin
                    verdict = VERDICT_BAD;
                end else if (fill >= flen) begin
                    parity = '0;
                    for (i = 0; i + 1 < fill; i++)
                        parity = parity ^ scan_q[head + i];
                    parity  = ~parity;
                    verdict = (parity == scan_q[pos]) ? VERDICT_GOOD : VERDICT_BAD;
                end
            end
            if (verdict == VERDICT_OPEN && fill >= FRAME_MAX)
                verdict = VERDICT_BAD;
            case (verdict)
                VERDICT_GOOD: begin
                    for (i = 0; i < fill; i++) begin
                        beat.value   = scan_q[head + i];
                        beat.last    = (i + 1 == fill);
                        beat.dropped = drop_total;
                        expected_beats.push_back(beat);
                    end
                    pos++;
                    head = pos;
                end
                VERDICT_BAD: begin
                    // Drop only the first byte and look at the rest again.
                    count_drop();
                    head++;
                    pos = head;
                end
                default: begin
                    pos++;
                end
            endcase
        end
        win_fill = n - head;
        for (i = 0; i < win_fill; i++)
            win_bytes[i] = scan_q[head + i];
    endtask

    // ------------------------------------------------------------------------
    // Frame output side: random stalls and checking
    // ------------------------------------------------------------------------

    task automatic check_frame_beat(input frame_beat_t got);
        frame_beat_t want;
        if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected frame byte: data %02h last %0b dropped %0d",
                         got.value, got.last, got.dropped);
        end else begin
            want = expected_beats.pop_front();
            if (got.value !== want.value || got.last !== want.last ||
                got.dropped !== want.dropped) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Frame byte mismatch: expected %02h %0b %0d, got %02h %0b %0d",
                             want.value, want.last, want.dropped,
                             got.value, got.last, got.dropped);
            end
        end
    endtask

    // After each transfer the sink may hold tready low again, at random.
    always @(posedge i_clk) begin : frame_sink
        frame_beat_t got;
        int          hold;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            out_hold   <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.value   = o_m_tdata[BYTE_W-1:0];
                got.dropped = o_m_tdata[BYTE_W+CNT_W-1:BYTE_W];
                got.last    = o_m_tlast;
                check_frame_beat(got);
                hold = gaps_on ? $urandom_range(0, 4) : 0;
            end else begin
                hold = (out_hold > 0) ? out_hold - 1 : 0;
            end
            out_hold   <= hold;
            i_m_tready <= (hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Byte input side and register access
    // ------------------------------------------------------------------------

    // Send one received byte after a random gap and update the model once the
    // transfer has taken place.
    task automatic send_rx_byte(input logic [BYTE_W-1:0] value);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        rx_sent++;
        predict_rx_byte(value);
    endtask

    // Wait until every expected byte has come out and the block has had time
    // to finish any scan that produces nothing.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                             input logic [BYTE_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_SYNC: cfg_sync = value;
            CFG_LFI:  cfg_lfi  = value[LFI_W-1:0];
            CFG_OVH:  cfg_ovh  = value[OVH_W-1:0];
            default:  ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] sync_value,
                             input logic [BYTE_W-1:0] lfi_value,
                             input logic [BYTE_W-1:0] ovh_value);
        wait_idle();
        write_reg(CFG_SYNC, sync_value);
        write_reg(CFG_LFI, lfi_value);
        write_reg(CFG_OVH, ovh_value);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Build a frame of the given length for the current settings, optionally
    // damage it, and send its first keep bytes.
    task automatic send_frame(input int flen, input frame_damage_e damage,
                              input int keep);
        logic [BYTE_W-1:0] fb [0:FRAME_MAX-1];
        logic [BYTE_W-1:0] parity;
        int                i;
        fb[0] = cfg_sync;
        for (i = 1; i < flen; i++)
            fb[i] = 8'($urandom);
        if (cfg_lfi != 0)
            fb[cfg_lfi] = 8'(flen - int'(cfg_ovh));
        parity = '0;
        for (i = 0; i + 1 < flen; i++)
            parity = parity ^ fb[i];
        fb[flen-1] = ~parity;
        case (damage)
            DMG_CHECKSUM: fb[flen-1] = fb[flen-1] ^ 8'h01;
            DMG_BITFLIP: begin
                i     = $urandom_range(0, flen - 1);
                fb[i] = fb[i] ^ (8'h01 << $urandom_range(0, 7));
            end
            default: ;
        endcase
        for (i = 0; i < keep; i++)
            send_rx_byte(fb[i]);
    endtask

    // Noise leans towards the sync byte so that false starts are common.
    task automatic send_noise(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_rx_byte(($urandom_range(0, 2) == 0) ? cfg_sync : 8'($urandom));
    endtask

    // Pick a frame length that the current settings can accept, mostly short
    // ones; zero when no frame can ever pass.
    function automatic int pick_frame_len();
        int lo, hi;
        if (cfg_lfi == 0) begin
            lo = int'(cfg_sync) + int'(cfg_ovh);
            hi = lo;
        end else begin
            lo = (int'(cfg_lfi) + 2 > int'(cfg_ovh)) ? int'(cfg_lfi) + 2 : int'(cfg_ovh);
            hi = FRAME_MAX;
        end
        if (lo < 2 || lo > hi || lo > FRAME_MAX)
            return 0;
        if ($urandom_range(0, 3) != 0 && lo + 6 < hi)
            hi = lo + 6;
        return $urandom_range(lo, hi);
    endfunction

    // Mostly well-formed frames with random content, the rest damaged frames,
    // cut-off frames and loose bytes.
    task automatic run_random_traffic(input int budget);
        int first, flen, pick;
        first = rx_sent;
        while (rx_sent - first < budget) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            flen    = pick_frame_len();
            pick    = $urandom_range(0, 9);
            if (flen == 0 || pick == 9)
                send_noise($urandom_range(1, 4));
            else if (pick <= 5)
                send_frame(flen, DMG_NONE, flen);
            else if (pick == 6)
                send_frame(flen, DMG_BITFLIP, flen);
            else if (pick == 7)
                send_frame(flen, DMG_CHECKSUM, flen);
            else
                send_frame(flen, DMG_NONE, $urandom_range(1, flen - 1));
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hunting, shortest frame, bad checksum, oversized length and a false
    // start just ahead of a good frame, all at the reset settings.
    task automatic test_directed_default();
        int i;
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(8'hAA);
        send_frame(int'(OVH_RST), DMG_NONE, int'(OVH_RST));
        send_frame(int'(OVH_RST) + 1, DMG_CHECKSUM, int'(OVH_RST) + 1);
        send_rx_byte(cfg_sync);
        for (i = 1; i < int'(LFI_RST); i++)
            send_rx_byte(8'($urandom));
        send_rx_byte(8'(FRAME_MAX + 1 - int'(OVH_RST)));
        send_rx_byte(8'($urandom));
        send_rx_byte(cfg_sync);
        send_frame(int'(OVH_RST), DMG_NONE, int'(OVH_RST));
    endtask

    task automatic test_random_default();
        configure(SYNC_RST, LFI_RST, OVH_RST);
        send_frame(FRAME_MAX, DMG_NONE, FRAME_MAX);
        run_random_traffic(40);
    endtask

    task automatic test_low_limits();
        configure(8'h00, 8'd1, 8'd2);
        run_random_traffic(25);
    endtask

    // Length byte in the last place of a full-size window: windows fill up and are mostly rejected.
    // The index is written with spare upper bits set.
    task automatic test_high_limits();
        configure(8'hFF, 8'hFF, 8'd32);
        run_random_traffic(15);
    endtask

    // Length read from the sync byte itself, then noise under a one-byte frame length.
    task automatic test_length_in_sync();
        configure(8'd3, 8'd0, 8'd4);
        run_random_traffic(15);
        configure(8'd1, 8'd0, 8'd0);
        send_noise(6);
    endtask

    task automatic test_short_overhead();
        configure(8'($urandom), 8'd2, 8'd1);
        run_random_traffic(15);
        configure(8'($urandom), 8'd5, 8'd0);
        run_random_traffic(15);
    endtask

    task automatic test_oversized_overhead();
        configure(8'h55, 8'd3, 8'd63);
        run_random_traffic(10);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_default();
        test_random_default();
        test_low_limits();
        test_high_limits();
        test_length_in_sync();
        test_short_overhead();
        test_oversized_overhead();
        wait_idle();
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sync_length_xor_frame_receiver.f =====
design/sxfr_pkg.sv
design/sxfr_ram.sv
design/sxfr_dp.sv
design/sxfr_ctrl.sv
design/sync_length_xor_frame_receiver.sv
dv/sync_length_xor_frame_receiver_tb.sv
